>>> src/psm_pkg.sv
package psm_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int OUT_W       = 32;

  localparam int PART_FIELD_W = 3;
  localparam int BIN_FIELD_W  = 9;

  // Saturation bounds of the Q9.23 result.
  localparam longint SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAT_MIN = -64'sh0000_0000_8000_0000;

  // Configuration register map.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS  = 1'b1;
  localparam int PARTS_W = 4;
  localparam int BINS_W  = 10;
  localparam logic [PARTS_W-1:0] PARTS_RST = 4'd1;
  localparam logic [BINS_W-1:0]  BINS_RST  = 10'd512;

  // Request operations.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  typedef struct packed {
    logic                          operation;
    logic [PART_FIELD_W-1:0]       partition;
    logic [BIN_FIELD_W-1:0]        bin;
    logic signed [SAMPLE_BITS-1:0] value_re;
    logic signed [SAMPLE_BITS-1:0] value_im;
  } in_req_t;

  typedef struct packed {
    logic [BIN_FIELD_W-1:0]  out_bin;
    logic signed [OUT_W-1:0] sum_re;
    logic signed [OUT_W-1:0] sum_im;
    logic                    frame_end;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLOT,
    ST_READ,
    ST_MUL,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // The four partial products of one complex multiply, in issue order.
  typedef enum logic [1:0] {
    TERM_RR,
    TERM_II,
    TERM_RI,
    TERM_IR
  } term_e;

endpackage

>>> src/partitioned_spectral_mac.sv
// Frequency-domain multiply-accumulate core of a uniformly partitioned convolver.
// A load request (operation 0) writes one complex filter bin into the filter store
// when its partition and bin lie within the store, and gives no response. A push
// request (operation 1) writes its bin into the current slot of the ring of past
// input spectra and returns the sum over the partitions in use of filter[p][bin] *
// ring[(slot - p) mod P][bin], rounded half up and saturated to Q9.23; the last bin
// of a frame advances the slot. A push first realigns the slot if P was reduced,
// then for each of the P partitions in use does one registered read of both stores
// and four passes through the one shared 24x24 multiplier. Pushes with a bin beyond
// the frame are dropped and give no response. After reset all MAX_PARTITIONS *
// 2**ceil(log2(MAX_BINS)) entries of both stores are cleared one entry per cycle,
// during which no request is taken; configuration writes are accepted at any time.
module partitioned_spectral_mac #(
  parameter int MAX_BINS       = 512,
  parameter int MAX_PARTITIONS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [psm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [psm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  psm_pkg::in_req_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output psm_pkg::out_rsp_t               out_rsp_o
);

  localparam int SB     = psm_pkg::SAMPLE_BITS;
  localparam int MW     = 2 * SB;
  localparam int BW     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int SW     = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int DEPTH  = MAX_PARTITIONS * (2 ** BW);
  localparam int AW     = $clog2(DEPTH);
  localparam int NPW    = $clog2(MAX_PARTITIONS + 1);
  localparam int NBW    = $clog2(MAX_BINS + 1);
  localparam int ACC_W  = MW + $clog2(2 * MAX_PARTITIONS) + 1;
  localparam int SH_W   = ACC_W - psm_pkg::FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (psm_pkg::FRAC_BITS - 1));

  // Configuration.
  logic [psm_pkg::PARTS_W-1:0] cfg_parts_q;
  logic [psm_pkg::BINS_W-1:0]  cfg_bins_q;
  logic [NPW-1:0]              np;
  logic [NBW-1:0]              nb;

  // Sequencer.
  psm_pkg::state_e state_q, state_d;
  psm_pkg::term_e  term_q, term_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [SW-1:0]   slot_q, slot_d;
  logic [SW-1:0]   part_q, part_d;
  logic [SW-1:0]   row_q, row_d;
  logic            prod_vld_q, prod_vld_d;
  psm_pkg::term_e  prod_term_q;
  logic            out_vld_q, out_vld_d;
  logic            acc_clr;
  logic            out_load;

  // Request capture.
  logic                        in_acc;
  logic                        load_ok;
  logic                        push_ok;
  logic                        cap_en;
  logic [psm_pkg::BIN_FIELD_W-1:0] bin_q;
  logic [MW-1:0]               val_q;
  logic                        fend_q;

  // Stores.
  logic [MW-1:0] fmem [DEPTH];
  logic [MW-1:0] rmem [DEPTH];
  logic          f_we, r_we, rd_en;
  logic [AW-1:0] f_waddr, r_waddr, f_raddr, r_raddr;
  logic [MW-1:0] f_wdata, r_wdata;
  logic [MW-1:0] f_rd_q, r_rd_q;

  // Datapath.
  logic signed [SB-1:0]    op_a, op_b;
  logic signed [MW-1:0]    prod_d, prod_q;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
  psm_pkg::out_rsp_t       out_rsp_d, out_rsp_q;

  function automatic logic signed [psm_pkg::OUT_W-1:0] rnd_sat(
    input logic signed [ACC_W-1:0] a
  );
    logic signed [ACC_W-1:0] r;
    logic signed [SH_W-1:0]  s;
    r = a + RND_HALF;
    s = SH_W'(r >>> psm_pkg::FRAC_BITS);
    if (longint'(s) > psm_pkg::SAT_MAX) begin
      rnd_sat = psm_pkg::OUT_W'(psm_pkg::SAT_MAX);
    end else if (longint'(s) < psm_pkg::SAT_MIN) begin
      rnd_sat = psm_pkg::OUT_W'(psm_pkg::SAT_MIN);
    end else begin
      rnd_sat = psm_pkg::OUT_W'(s);
    end
  endfunction

  // Register values outside the supported range are clamped.
  always_comb begin
    if (cfg_parts_q == '0) begin
      np = NPW'(1);
    end else if (32'(cfg_parts_q) > MAX_PARTITIONS) begin
      np = NPW'(MAX_PARTITIONS);
    end else begin
      np = NPW'(cfg_parts_q);
    end
    if (cfg_bins_q == '0) begin
      nb = NBW'(1);
    end else if (32'(cfg_bins_q) > MAX_BINS) begin
      nb = NBW'(MAX_BINS);
    end else begin
      nb = NBW'(cfg_bins_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_parts_q <= psm_pkg::PARTS_RST;
      cfg_bins_q  <= psm_pkg::BINS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psm_pkg::CFG_PARTS: cfg_parts_q <= cfg_data_i[psm_pkg::PARTS_W-1:0];
        psm_pkg::CFG_BINS:  cfg_bins_q  <= cfg_data_i[psm_pkg::BINS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == psm_pkg::ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign load_ok    = (32'(in_req_i.partition) < MAX_PARTITIONS) &&
                      (32'(in_req_i.bin) < MAX_BINS);
  assign push_ok    = 32'(in_req_i.bin) < 32'(nb);

  always_comb begin
    state_d    = state_q;
    term_d     = term_q;
    clr_d      = clr_q;
    slot_d     = slot_q;
    part_d     = part_q;
    row_d      = row_q;
    prod_vld_d = 1'b0;
    out_vld_d  = out_vld_q & ~out_ready_i;
    acc_clr    = 1'b0;
    out_load   = 1'b0;
    cap_en     = 1'b0;
    rd_en      = 1'b0;
    f_we       = 1'b0;
    r_we       = 1'b0;
    f_waddr    = AW'({SW'(in_req_i.partition), BW'(in_req_i.bin)});
    f_wdata    = {in_req_i.value_re, in_req_i.value_im};
    r_waddr    = AW'({slot_q, BW'(bin_q)});
    r_wdata    = val_q;
    f_raddr    = AW'({part_q, BW'(bin_q)});
    r_raddr    = AW'({row_q, BW'(bin_q)});

    unique case (state_q)
      psm_pkg::ST_CLEAR: begin
        f_we    = 1'b1;
        r_we    = 1'b1;
        f_waddr = clr_q;
        r_waddr = clr_q;
        f_wdata = '0;
        r_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = psm_pkg::ST_IDLE;
        end
      end
      psm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_req_i.operation == psm_pkg::OP_LOAD) begin
            f_we = load_ok;
          end else if (push_ok) begin
            cap_en  = 1'b1;
            state_d = psm_pkg::ST_SLOT;
          end
        end
      end
      psm_pkg::ST_SLOT: begin
        // After the ring was shortened the slot is folded back one ring length a cycle.
        if (32'(slot_q) >= 32'(np)) begin
          slot_d = slot_q - SW'(np);
        end else begin
          r_we    = 1'b1;
          row_d   = slot_q;
          part_d  = '0;
          acc_clr = 1'b1;
          state_d = psm_pkg::ST_READ;
        end
      end
      psm_pkg::ST_READ: begin
        rd_en   = 1'b1;
        term_d  = psm_pkg::TERM_RR;
        state_d = psm_pkg::ST_MUL;
      end
      psm_pkg::ST_MUL: begin
        prod_vld_d = 1'b1;
        case (term_q)
          psm_pkg::TERM_RR: term_d = psm_pkg::TERM_II;
          psm_pkg::TERM_II: term_d = psm_pkg::TERM_RI;
          psm_pkg::TERM_RI: term_d = psm_pkg::TERM_IR;
          default: begin
            row_d = (row_q == '0) ? SW'(np - 1'b1) : row_q - 1'b1;
            if (32'(part_q) + 1 < 32'(np)) begin
              part_d  = part_q + 1'b1;
              state_d = psm_pkg::ST_READ;
            end else begin
              state_d = psm_pkg::ST_DRAIN;
            end
          end
        endcase
      end
      psm_pkg::ST_DRAIN: begin
        state_d = psm_pkg::ST_DONE;
      end
      psm_pkg::ST_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          if (fend_q) begin
            slot_d = (32'(slot_q) + 1 < 32'(np)) ? SW'(slot_q + 1'b1) : '0;
          end
          state_d = psm_pkg::ST_IDLE;
        end
      end
      default: state_d = psm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psm_pkg::ST_CLEAR;
      term_q      <= psm_pkg::TERM_RR;
      clr_q       <= '0;
      slot_q      <= '0;
      part_q      <= '0;
      row_q       <= '0;
      prod_vld_q  <= 1'b0;
      prod_term_q <= psm_pkg::TERM_RR;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      clr_q       <= clr_d;
      slot_q      <= slot_d;
      part_q      <= part_d;
      row_q       <= row_d;
      prod_vld_q  <= prod_vld_d;
      prod_term_q <= term_q;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      fmem[f_waddr] <= f_wdata;
    end
    if (rd_en) begin
      f_rd_q <= fmem[f_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      rmem[r_waddr] <= r_wdata;
    end
    if (rd_en) begin
      r_rd_q <= rmem[r_raddr];
    end
  end

  // Operand selection for the shared multiplier; entries hold {re, im}.
  always_comb begin
    case (term_q)
      psm_pkg::TERM_RR: begin
        op_a = f_rd_q[MW-1:SB];
        op_b = r_rd_q[MW-1:SB];
      end
      psm_pkg::TERM_II: begin
        op_a = f_rd_q[SB-1:0];
        op_b = r_rd_q[SB-1:0];
      end
      psm_pkg::TERM_RI: begin
        op_a = f_rd_q[MW-1:SB];
        op_b = r_rd_q[SB-1:0];
      end
      default: begin
        op_a = f_rd_q[SB-1:0];
        op_b = r_rd_q[MW-1:SB];
      end
    endcase
    prod_d = op_a * op_b;
  end

  always_comb begin
    out_rsp_d.out_bin   = bin_q;
    out_rsp_d.sum_re    = rnd_sat(acc_re_q);
    out_rsp_d.sum_im    = rnd_sat(acc_im_q);
    out_rsp_d.frame_end = fend_q;
  end

  always_ff @(posedge clk_i) begin
    if (cap_en) begin
      bin_q  <= in_req_i.bin;
      val_q  <= {in_req_i.value_re, in_req_i.value_im};
      fend_q <= (32'(in_req_i.bin) == 32'(nb) - 1);
    end
    prod_q <= prod_d;
    if (acc_clr) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (prod_vld_q) begin
      case (prod_term_q)
        psm_pkg::TERM_RR: acc_re_q <= acc_re_q + ACC_W'(prod_q);
        psm_pkg::TERM_II: acc_re_q <= acc_re_q - ACC_W'(prod_q);
        default:          acc_im_q <= acc_im_q + ACC_W'(prod_q);
      endcase
    end
    if (out_load) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

>>> tb/sv/psm_checker.sv
module psm_checker #(
  parameter int MAX_BINS       = 512,
  parameter int MAX_PARTITIONS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [psm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [psm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  psm_pkg::in_req_t               in_req_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  psm_pkg::out_rsp_t              out_rsp_i,
  output int unsigned                    pending_o,
  output int unsigned                    fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;
  localparam int SB          = psm_pkg::SAMPLE_BITS;
  localparam int OW          = psm_pkg::OUT_W;

  logic signed [SB-1:0] filt_re [MAX_PARTITIONS][MAX_BINS];
  logic signed [SB-1:0] filt_im [MAX_PARTITIONS][MAX_BINS];
  logic signed [SB-1:0] ring_re [MAX_PARTITIONS][MAX_BINS];
  logic signed [SB-1:0] ring_im [MAX_PARTITIONS][MAX_BINS];
  logic [psm_pkg::PARTS_W-1:0] parts_reg;
  logic [psm_pkg::BINS_W-1:0]  bins_reg;
  int unsigned                 ring_slot;
  psm_pkg::out_rsp_t           expected_sums [$];

  // Round half up to the output grid, then clamp to the Q9.23 range.
  function automatic logic signed [OW-1:0] round_sat(input longint acc);
    longint q;
    q = (acc + (longint'(1) <<< (psm_pkg::FRAC_BITS - 1))) >>> psm_pkg::FRAC_BITS;
    if (q > psm_pkg::SAT_MAX) return OW'(psm_pkg::SAT_MAX);
    if (q < psm_pkg::SAT_MIN) return OW'(psm_pkg::SAT_MIN);
    return OW'(q);
  endfunction

  task automatic predict_request(input psm_pkg::in_req_t req);
    int unsigned       np, nb, cur, r, p;
    longint            acc_re, acc_im;
    psm_pkg::out_rsp_t rsp;
    if (req.operation == psm_pkg::OP_LOAD) begin
      if (req.partition < MAX_PARTITIONS && req.bin < MAX_BINS) begin
        filt_re[req.partition][req.bin] = req.value_re;
        filt_im[req.partition][req.bin] = req.value_im;
      end
    end else begin
      np = (parts_reg == 0) ? 1 : (parts_reg > MAX_PARTITIONS) ? MAX_PARTITIONS : parts_reg;
      nb = (bins_reg == 0) ? 1 : (bins_reg > MAX_BINS) ? MAX_BINS : bins_reg;
      if (req.bin < nb) begin
        cur = ring_slot % np;
        ring_re[cur][req.bin] = req.value_re;
        ring_im[cur][req.bin] = req.value_im;
        acc_re = 0;
        acc_im = 0;
        for (p = 0; p < np; p++) begin
          r = (cur + np - p) % np;
          acc_re += longint'(filt_re[p][req.bin]) * longint'(ring_re[r][req.bin]);
          acc_re -= longint'(filt_im[p][req.bin]) * longint'(ring_im[r][req.bin]);
          acc_im += longint'(filt_re[p][req.bin]) * longint'(ring_im[r][req.bin]);
          acc_im += longint'(filt_im[p][req.bin]) * longint'(ring_re[r][req.bin]);
        end
        rsp.out_bin   = req.bin;
        rsp.sum_re    = round_sat(acc_re);
        rsp.sum_im    = round_sat(acc_im);
        rsp.frame_end = (req.bin == nb - 1);
        expected_sums.push_back(rsp);
        if (rsp.frame_end) ring_slot = (cur + 1 < np) ? cur + 1 : 0;
        else ring_slot = cur;
      end
    end
  endtask

  task automatic check_response(input psm_pkg::out_rsp_t got);
    psm_pkg::out_rsp_t want;
    if (expected_sums.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= MAX_REPORTS)
        $display("%0t: response for bin %0d with no push outstanding", $realtime, got.out_bin);
    end else begin
      want = expected_sums.pop_front();
      if (got.out_bin !== want.out_bin || got.sum_re !== want.sum_re ||
          got.sum_im !== want.sum_im || got.frame_end !== want.frame_end) begin
        fail_count_o++;
        if (fail_count_o <= MAX_REPORTS)
          $display({"%0t: mismatch exp bin %0d re %0d im %0d end %0b, ",
                    "got bin %0d re %0d im %0d end %0b"},
                   $realtime, want.out_bin, want.sum_re, want.sum_im, want.frame_end,
                   got.out_bin, got.sum_re, got.sum_im, got.frame_end);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < MAX_PARTITIONS; p++) begin
        for (int b = 0; b < MAX_BINS; b++) begin
          filt_re[p][b] = '0;
          filt_im[p][b] = '0;
          ring_re[p][b] = '0;
          ring_im[p][b] = '0;
        end
      end
      expected_sums.delete();
      ring_slot    = 0;
      fail_count_o = 0;
      parts_reg    = psm_pkg::PARTS_RST;
      bins_reg     = psm_pkg::BINS_RST;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == psm_pkg::CFG_PARTS) begin
          parts_reg = cfg_data_i[psm_pkg::PARTS_W-1:0];
        end else if (cfg_idx_i == psm_pkg::CFG_BINS) begin
          bins_reg = cfg_data_i[psm_pkg::BINS_W-1:0];
        end
      end
      if (out_valid_i && out_ready_i) check_response(out_rsp_i);
      if (in_valid_i && in_ready_i) predict_request(in_req_i);
    end
    pending_o = expected_sums.size();
  end

endmodule

>>> tb/sv/partitioned_spectral_mac_tb.sv
module partitioned_spectral_mac_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BINS        = 512;
  localparam int MAX_PARTITIONS  = 8;
  localparam int N_ITEMS         = 1550;
  localparam int DRAIN_CYCLES    = 80;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int MAX_SMALL_FRAME = 12;
  localparam int SB              = psm_pkg::SAMPLE_BITS;
  localparam int PFW             = psm_pkg::PART_FIELD_W;
  localparam int BFW             = psm_pkg::BIN_FIELD_W;

  localparam logic signed [SB-1:0] Q_MAX  = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] Q_MIN  = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] Q_HALF = {2'b01, {(SB-2){1'b0}}};

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [psm_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [psm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  psm_pkg::in_req_t               in_req = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  psm_pkg::out_rsp_t              out_rsp;
  int unsigned                    pending;
  int unsigned                    fail_count;

  int unsigned cycle_count = 0;
  int unsigned frame_len = MAX_BINS;
  int unsigned ring_len = 1;
  int unsigned loads_sent = 0;
  int unsigned pushes_sent = 0;
  int unsigned ignored_sent = 0;
  int unsigned settings_used = 0;
  int unsigned burst_left = 0;
  bit          bursty = 1'b0;
  int unsigned ready_mode = 0;
  int unsigned ready_left = 0;

  partitioned_spectral_mac #(
    .MAX_BINS      (MAX_BINS),
    .MAX_PARTITIONS(MAX_PARTITIONS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  psm_checker #(
    .MAX_BINS      (MAX_BINS),
    .MAX_PARTITIONS(MAX_PARTITIONS)
  ) u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_i   (out_rsp),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // The response side switches between randomly chosen stall patterns.
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(50, 400);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0: out_ready = 1'b1;
      1: out_ready = 1'($urandom_range(0, 1));
      2: out_ready = (ready_left % 5) != 0;
      default: out_ready = ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [SB-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return '1;
      4: return SB'($urandom_range(0, 255));
      default: return SB'($urandom());
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken,
  // with valid still high so that a following request goes out back to back.
  task automatic send_req(input logic           op,
                          input logic [PFW-1:0] part,
                          input logic [BFW-1:0] bin_idx,
                          input logic [SB-1:0]  re,
                          input logic [SB-1:0]  im);
    psm_pkg::in_req_t req;
    req.operation = op;
    req.partition = part;
    req.bin       = bin_idx;
    req.value_re  = re;
    req.value_im  = im;
    if (bursty && burst_left == 0) begin
      in_valid = 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 60)) @(negedge clk);
      else repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_req   = req;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (op == psm_pkg::OP_LOAD) loads_sent++;
    else if (bin_idx < frame_len) pushes_sent++;
    else ignored_sent++;
  endtask

  task automatic push_random(input int unsigned bin_idx);
    send_req(psm_pkg::OP_PUSH, PFW'($urandom()), BFW'(bin_idx),
             rand_sample(), rand_sample());
  endtask

  task automatic load_random();
    logic [PFW-1:0] part;
    logic [BFW-1:0] bin_idx;
    if ($urandom_range(0, 3) == 0) begin
      part    = PFW'($urandom());
      bin_idx = BFW'($urandom());
    end else begin
      part    = PFW'($urandom_range(0, ring_len - 1));
      bin_idx = BFW'($urandom_range(0, frame_len - 1));
    end
    send_req(psm_pkg::OP_LOAD, part, bin_idx, rand_sample(), rand_sample());
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [psm_pkg::PARTS_W-1:0] parts_raw,
                           input logic [psm_pkg::BINS_W-1:0]  bins_raw);
    cfg_we   = 1'b1;
    cfg_idx  = psm_pkg::CFG_PARTS;
    cfg_data = psm_pkg::CFG_DATA_W'(parts_raw);
    @(negedge clk);
    cfg_idx  = psm_pkg::CFG_BINS;
    cfg_data = psm_pkg::CFG_DATA_W'(bins_raw);
    @(negedge clk);
    cfg_we    = 1'b0;
    ring_len  = (parts_raw == 0) ? 1 : (parts_raw > MAX_PARTITIONS) ? MAX_PARTITIONS : parts_raw;
    frame_len = (bins_raw == 0) ? 1 : (bins_raw > MAX_BINS) ? MAX_BINS : bins_raw;
    settings_used++;
  endtask

  task automatic run_random_phase();
    logic [psm_pkg::PARTS_W-1:0] parts_raw;
    logic [psm_pkg::BINS_W-1:0]  bins_raw;
    int unsigned                 n_frames, span, j, k, tmp;
    int unsigned                 order [MAX_SMALL_FRAME];
    settle();
    if ($urandom_range(0, 3) == 0) parts_raw = psm_pkg::PARTS_W'($urandom_range(0, 15));
    else parts_raw = psm_pkg::PARTS_W'($urandom_range(1, MAX_PARTITIONS));
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: bins_raw = '0;
        1: bins_raw = psm_pkg::BINS_W'(MAX_BINS);
        2: bins_raw = '1;
        default: bins_raw = psm_pkg::BINS_W'($urandom_range(MAX_SMALL_FRAME + 1, 1023));
      endcase
    end else begin
      bins_raw = psm_pkg::BINS_W'($urandom_range(1, MAX_SMALL_FRAME));
    end
    configure(parts_raw, bins_raw);
    bursty = ($urandom_range(0, 3) != 0);
    repeat ($urandom_range(1, 12)) load_random();
    if (frame_len <= MAX_SMALL_FRAME) begin
      n_frames = $urandom_range(1, 5);
      repeat (n_frames) begin
        for (j = 0; j < frame_len; j++) order[j] = j;
        if ($urandom_range(0, 3) == 0) begin
          for (j = frame_len - 1; j > 0; j--) begin
            k        = $urandom_range(0, j);
            tmp      = order[j];
            order[j] = order[k];
            order[k] = tmp;
          end
        end
        for (j = 0; j < frame_len; j++) begin
          if ($urandom_range(0, 19) == 0) push_random($urandom_range(frame_len, MAX_BINS - 1));
          // An occasional dropped or repeated bin breaks the frame.
          case ($urandom_range(0, 29))
            0: ;
            1: begin
              push_random(order[j]);
              push_random(order[j]);
            end
            default: push_random(order[j]);
          endcase
          if ($urandom_range(0, 15) == 0) load_random();
        end
      end
    end else begin
      span = $urandom_range(8, 24);
      repeat (span) push_random($urandom_range(0, frame_len - 1));
      push_random(frame_len - 1);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Two partitions, four bins: extreme values, a partition outside the ring,
    // the last bin arriving first, and bins beyond the frame.
    configure(4'd2, 10'd4);
    send_req(psm_pkg::OP_LOAD, 3'd0, 9'd0, Q_MAX, Q_MIN);
    send_req(psm_pkg::OP_LOAD, 3'd1, 9'd0, Q_MIN, Q_MIN);
    send_req(psm_pkg::OP_LOAD, 3'd7, 9'd511, Q_MAX, Q_MAX);
    send_req(psm_pkg::OP_LOAD, 3'd1, 9'd3, Q_HALF, '1);
    send_req(psm_pkg::OP_PUSH, 3'd0, 9'd3, Q_MAX, Q_MIN);
    send_req(psm_pkg::OP_PUSH, 3'd7, 9'd0, Q_MAX, Q_MAX);
    send_req(psm_pkg::OP_PUSH, 3'd0, 9'd0, Q_MIN, Q_MIN);
    send_req(psm_pkg::OP_PUSH, 3'd0, 9'd1, '0, '0);
    send_req(psm_pkg::OP_PUSH, 3'd0, 9'd2, 24'sd1, '1);
    send_req(psm_pkg::OP_PUSH, 3'd0, 9'd3, Q_MIN, Q_MAX);
    send_req(psm_pkg::OP_PUSH, 3'd0, 9'd4, Q_MAX, Q_MAX);
    send_req(psm_pkg::OP_PUSH, 3'd0, 9'd511, Q_MIN, Q_MIN);

    // Out-of-range counts: eight partitions, one bin per frame, so every push within
    // the frame moves the slot on.
    settle();
    configure(4'd15, 10'd0);
    repeat (6) push_random(0);
    push_random(1);

    // Shrinking the ring leaves the slot past its end.
    settle();
    configure(4'd3, 10'd1023);
    push_random(0);
    send_req(psm_pkg::OP_PUSH, 3'd0, 9'd511, Q_MAX, Q_MIN);

    settle();
    configure(4'd0, 10'd2);
    send_req(psm_pkg::OP_LOAD, 3'd0, 9'd1, Q_MIN, Q_MIN);
    send_req(psm_pkg::OP_PUSH, 3'd0, 9'd1, Q_MIN, Q_MIN);
    push_random(0);

    while (loads_sent + pushes_sent < N_ITEMS) run_random_phase();

    settle();
    $display("Sent %0d filter loads, %0d pushes and %0d out-of-frame pushes",
             loads_sent, pushes_sent, ignored_sent);
    $display("across %0d partition and bin count settings, extremes included.", settings_used);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d failures", fail_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/psm_pkg.sv
src/partitioned_spectral_mac.sv
tb/sv/psm_checker.sv
tb/sv/partitioned_spectral_mac_tb.sv
